>>> rtl/core/wdqi_pkg.sv
`default_nettype none

package wdqi_pkg;

    localparam int TEMP_W      = 16;
    localparam int DENS_W      = 24;
    localparam int DL1_W       = DENS_W + 1;
    localparam int DL2_W       = DENS_W + 3;
    localparam int LO_W        = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int ROM_ENTRIES = 102;

    localparam int TABLE_DEPTH_DEF = 102;
    localparam int FRAC_BITS_DEF   = 8;

    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST  = 16'sd0;
    localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST = 16'sd25600;
    localparam logic [DENS_W-1:0]        DENS_BELOW_RST = 24'd9998395;
    localparam logic [DENS_W-1:0]        DENS_ABOVE_RST = 24'd9583449;

    typedef enum logic [1:0] {
        FLAG_INTERP = 2'd0,
        FLAG_BELOW  = 2'd1,
        FLAG_ABOVE  = 2'd2
    } range_flag_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_LIMIT  = 2'd0,
        REG_HIGH_LIMIT = 2'd1,
        REG_DENS_BELOW = 2'd2,
        REG_DENS_ABOVE = 2'd3
    } cfg_reg_t;

    // Range decision and the default density that travel beside the datapath.
    typedef struct packed {
        range_flag_t         flag;
        logic [DENS_W-1:0]   dflt;
    } side_t;

    // Density per whole degree Celsius, units of 1e-4 kg per cubic meter.
    localparam logic [DENS_W-1:0] DENS_ROM [0:ROM_ENTRIES-1] = '{
        24'd9998395, 24'd9998986, 24'd9999399, 24'd9999642, 24'd9999719, 24'd9999637,
        24'd9999399, 24'd9999011, 24'd9998476, 24'd9997800, 24'd9996985, 24'd9996036,
        24'd9994957, 24'd9993752, 24'd9992422, 24'd9990972, 24'd9989404, 24'd9987721,
        24'd9985925, 24'd9984020, 24'd9982009, 24'd9979891, 24'd9977671, 24'd9975350,
        24'd9972930, 24'd9970413, 24'd9967800, 24'd9965095, 24'd9962297, 24'd9959409,
        24'd9956431, 24'd9953367, 24'd9950217, 24'd9946982, 24'd9943665, 24'd9940266,
        24'd9936786, 24'd9933229, 24'd9929594, 24'd9925883, 24'd9922097, 24'd9918257,
        24'd9914321, 24'd9910313, 24'd9906234, 24'd9902084, 24'd9897864, 24'd9893575,
        24'd9889219, 24'd9884794, 24'd9880305, 24'd9875748, 24'd9871127, 24'd9866443,
        24'd9861694, 24'd9856883, 24'd9852010, 24'd9847075, 24'd9842079, 24'd9837023,
        24'd9831908, 24'd9826733, 24'd9821500, 24'd9816209, 24'd9810861, 24'd9805455,
        24'd9799993, 24'd9794476, 24'd9788903, 24'd9783274, 24'd9777591, 24'd9771854,
        24'd9766063, 24'd9760219, 24'd9754321, 24'd9748372, 24'd9742369, 24'd9736316,
        24'd9730211, 24'd9724054, 24'd9717847, 24'd9711589, 24'd9705281, 24'd9698923,
        24'd9692515, 24'd9686058, 24'd9679552, 24'd9672997, 24'd9666394, 24'd9659742,
        24'd9653043, 24'd9646295, 24'd9639500, 24'd9632657, 24'd9625768, 24'd9618831,
        24'd9611848, 24'd9604818, 24'd9597741, 24'd9590618, 24'd9583449, 24'd9576451
    };

    // Entries past the end of the table read as zero.
    function automatic logic [DENS_W-1:0] dens_rom(input logic [7:0] idx);
        logic [DENS_W-1:0] val;
        val = '0;
        if (idx < 8'(ROM_ENTRIES)) begin
            val = DENS_ROM[idx[6:0]];
        end
        return val;
    endfunction

    // Width of x - S, where x is a 16-bit offset and S = 2^f.
    function automatic int xm_width(input int f);
        return ((f + 1 > TEMP_W) ? f + 1 : TEMP_W) + 1;
    endfunction

    function automatic int inner_width(input int f);
        return DL2_W + xm_width(f) + 1;
    endfunction

    function automatic int prod_width(input int f);
        return inner_width(f) + TEMP_W;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/water_density_quadratic_interp_core.sv
// Throughput: one item per cycle while the output is not stalled; eight register stages, each with its own valid bit.
// The widest step is the interpolation product, split into 24x16 and 22x16 halves at the default FRAC_BITS.
// A stalled output holds its stage; bubbles ahead of it are still filled from s_.
// Reset (aresetn low, synchronous) empties every stage and loads the register defaults.
`default_nettype none

module water_density_quadratic_interp_core #(
    parameter int TABLE_DEPTH = wdqi_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = wdqi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [15:0]                         s_tdata,   // [15:0] temp_q8_8
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [23:0]                              m_tdata,   // [23:0] density_value
    output logic [1:0]                               m_tuser,   // [1:0] range_flag
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wdqi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wdqi_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int XM_W   = wdqi_pkg::xm_width(FRAC_BITS);
    localparam int PROD_W = wdqi_pkg::prod_width(FRAC_BITS);

    logic signed [wdqi_pkg::TEMP_W-1:0] low_limit_reg, high_limit_reg;
    logic [wdqi_pkg::DENS_W-1:0]        dens_below_reg, dens_above_reg;

    logic                               fr_valid, fr_ready;
    wdqi_pkg::side_t                    fr_side;
    logic [wdqi_pkg::DENS_W-1:0]        fr_d0;
    logic signed [wdqi_pkg::DL1_W-1:0]  fr_dl1;
    logic signed [wdqi_pkg::DL2_W-1:0]  fr_dl2;
    logic signed [wdqi_pkg::TEMP_W-1:0] fr_x;
    logic signed [XM_W-1:0]             fr_xm;

    logic                               po_valid, po_ready;
    wdqi_pkg::side_t                    po_side;
    logic [wdqi_pkg::DENS_W-1:0]        po_d0;
    logic signed [PROD_W-1:0]           po_prod;

    wdqi_pkg::range_flag_t              out_flag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= wdqi_pkg::LOW_LIMIT_RST;
            high_limit_reg <= wdqi_pkg::HIGH_LIMIT_RST;
            dens_below_reg <= wdqi_pkg::DENS_BELOW_RST;
            dens_above_reg <= wdqi_pkg::DENS_ABOVE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (wdqi_pkg::cfg_reg_t'(cfg_index))
                wdqi_pkg::REG_LOW_LIMIT:  begin
                    low_limit_reg <= $signed(cfg_data[wdqi_pkg::TEMP_W-1:0]);
                end
                wdqi_pkg::REG_HIGH_LIMIT: begin
                    high_limit_reg <= $signed(cfg_data[wdqi_pkg::TEMP_W-1:0]);
                end
                wdqi_pkg::REG_DENS_BELOW: begin
                    dens_below_reg <= cfg_data[wdqi_pkg::DENS_W-1:0];
                end
                wdqi_pkg::REG_DENS_ABOVE: begin
                    dens_above_reg <= cfg_data[wdqi_pkg::DENS_W-1:0];
                end
            endcase
        end
    end

    wdqi_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_temp       ($signed(s_tdata)),
        .low_limit     (low_limit_reg),
        .high_limit    (high_limit_reg),
        .density_below (dens_below_reg),
        .density_above (dens_above_reg),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_side      (fr_side),
        .out_d0        (fr_d0),
        .out_dl1       (fr_dl1),
        .out_dl2       (fr_dl2),
        .out_x         (fr_x),
        .out_xm        (fr_xm)
    );

    wdqi_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_side   (fr_side),
        .in_d0     (fr_d0),
        .in_dl1    (fr_dl1),
        .in_dl2    (fr_dl2),
        .in_x      (fr_x),
        .in_xm     (fr_xm),
        .out_valid (po_valid),
        .out_ready (po_ready),
        .out_side  (po_side),
        .out_d0    (po_d0),
        .out_prod  (po_prod)
    );

    wdqi_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (po_valid),
        .in_ready  (po_ready),
        .in_side   (po_side),
        .in_d0     (po_d0),
        .in_prod   (po_prod),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_flag  (out_flag)
    );

    assign m_tuser = out_flag;

    // With the output stage empty, every stage behind it can advance.
    a_ready_when_drained: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready
    ) else $error("input stalled while the output stage is empty");

    // Reset leaves the pipeline empty.
    a_empty_after_reset: assert property (
        @(posedge aclk)
        !aresetn |=> !m_tvalid
    ) else $error("result presented right after reset");

endmodule

`default_nettype wire

>>> rtl/core/wdqi_front.sv
`default_nettype none

module wdqi_front #(
    parameter int TABLE_DEPTH = wdqi_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = wdqi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [wdqi_pkg::TEMP_W-1:0]      in_temp,
    input  wire logic signed [wdqi_pkg::TEMP_W-1:0]      low_limit,
    input  wire logic signed [wdqi_pkg::TEMP_W-1:0]      high_limit,
    input  wire logic [wdqi_pkg::DENS_W-1:0]             density_below,
    input  wire logic [wdqi_pkg::DENS_W-1:0]             density_above,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output wdqi_pkg::side_t                              out_side,
    output logic [wdqi_pkg::DENS_W-1:0]                  out_d0,
    output logic signed [wdqi_pkg::DL1_W-1:0]            out_dl1,
    output logic signed [wdqi_pkg::DL2_W-1:0]            out_dl2,
    output logic signed [wdqi_pkg::TEMP_W-1:0]           out_x,
    output logic signed [wdqi_pkg::xm_width(FRAC_BITS)-1:0] out_xm
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int XM_W  = wdqi_pkg::xm_width(FRAC_BITS);
    localparam int TOP_IDX = TABLE_DEPTH - 3;
    localparam logic signed [XM_W-1:0] S_VAL = XM_W'(1 << FRAC_BITS);

    // Stage 0: range decision, whole degree and fractional offset.
    logic                                   v0_reg;
    wdqi_pkg::side_t                        side0_reg, side0_next;
    logic [IDX_W-1:0]                       idx0_reg, idx0_next;
    logic signed [wdqi_pkg::TEMP_W-1:0]     x0_reg, x0_next;
    logic [wdqi_pkg::TEMP_W-1:0]            t_shift;
    logic [24:0]                            t0_base;
    logic signed [24:0]                     x_wide;
    logic                                   is_below, is_above;
    logic                                   ready0, ready1;

    // Stage 1: table reads and finite differences.
    logic                                   v1_reg;
    wdqi_pkg::side_t                        side1_reg;
    logic [wdqi_pkg::DENS_W-1:0]            d0_reg, d0_next, d1_val, d2_val;
    logic signed [wdqi_pkg::DL1_W-1:0]      dl1_reg, dl1_next;
    logic signed [wdqi_pkg::DL2_W-1:0]      dl2_reg, dl2_next;
    logic signed [wdqi_pkg::TEMP_W-1:0]     x1_reg;
    logic signed [XM_W-1:0]                 xm_reg, xm_next;

    assign ready1   = !v1_reg || out_ready;
    assign ready0   = !v0_reg || ready1;
    assign in_ready = ready0;

    always_comb begin
        is_below = in_temp <= low_limit;
        is_above = in_temp >= high_limit;
        side0_next.flag = is_below ? wdqi_pkg::FLAG_BELOW :
                          (is_above ? wdqi_pkg::FLAG_ABOVE : wdqi_pkg::FLAG_INTERP);
        side0_next.dflt = is_below ? density_below : density_above;

        t_shift = in_temp >> FRAC_BITS;
        if (in_temp[wdqi_pkg::TEMP_W-1]) begin
            idx0_next = '0;
        end else if (t_shift > wdqi_pkg::TEMP_W'(TOP_IDX)) begin
            idx0_next = IDX_W'(TOP_IDX);
        end else begin
            idx0_next = t_shift[IDX_W-1:0];
        end

        // A negative temperature has a zero base, and otherwise the whole-degree base
        // never exceeds the temperature, so x fits 16 bits.
        t0_base = 25'(idx0_next) << FRAC_BITS;
        x_wide  = 25'(in_temp) - $signed(t0_base);
        x0_next = x_wide[wdqi_pkg::TEMP_W-1:0];
    end

    always_comb begin
        d0_next  = wdqi_pkg::dens_rom(8'(idx0_reg));
        d1_val   = wdqi_pkg::dens_rom(8'(idx0_reg) + 8'd1);
        d2_val   = wdqi_pkg::dens_rom(8'(idx0_reg) + 8'd2);
        dl1_next = $signed({1'b0, d1_val}) - $signed({1'b0, d0_next});
        dl2_next = $signed({3'b000, d2_val}) - $signed({2'b00, d1_val, 1'b0})
                 + $signed({3'b000, d0_next});
        xm_next  = XM_W'(x0_reg) - S_VAL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            if (ready0) begin
                v0_reg <= in_valid;
            end
            if (ready1) begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready0 && in_valid) begin
            side0_reg <= side0_next;
            idx0_reg  <= idx0_next;
            x0_reg    <= x0_next;
        end
        if (ready1 && v0_reg) begin
            side1_reg <= side0_reg;
            d0_reg    <= d0_next;
            dl1_reg   <= dl1_next;
            dl2_reg   <= dl2_next;
            x1_reg    <= x0_reg;
            xm_reg    <= xm_next;
        end
    end

    assign out_valid = v1_reg;
    assign out_side  = side1_reg;
    assign out_d0    = d0_reg;
    assign out_dl1   = dl1_reg;
    assign out_dl2   = dl2_reg;
    assign out_x     = x1_reg;
    assign out_xm    = xm_reg;

endmodule

`default_nettype wire

>>> rtl/core/wdqi_poly.sv
`default_nettype none

module wdqi_poly #(
    parameter int FRAC_BITS = wdqi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire wdqi_pkg::side_t                            in_side,
    input  wire logic [wdqi_pkg::DENS_W-1:0]                in_d0,
    input  wire logic signed [wdqi_pkg::DL1_W-1:0]          in_dl1,
    input  wire logic signed [wdqi_pkg::DL2_W-1:0]          in_dl2,
    input  wire logic signed [wdqi_pkg::TEMP_W-1:0]         in_x,
    input  wire logic signed [wdqi_pkg::xm_width(FRAC_BITS)-1:0] in_xm,
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output wdqi_pkg::side_t                                 out_side,
    output logic [wdqi_pkg::DENS_W-1:0]                     out_d0,
    output logic signed [wdqi_pkg::prod_width(FRAC_BITS)-1:0] out_prod
);

    // Horner form of the Lagrange numerator:
    //   N = 2*S^2*d0 + x*(2*S*dl1 + dl2*(x - S))
    // This module forms the product x*(...) in four stages.
    localparam int XM_W    = wdqi_pkg::xm_width(FRAC_BITS);
    localparam int M1_W    = wdqi_pkg::DL2_W + XM_W;
    localparam int INNER_W = wdqi_pkg::inner_width(FRAC_BITS);
    localparam int PROD_W  = wdqi_pkg::prod_width(FRAC_BITS);
    localparam int LO_W    = wdqi_pkg::LO_W;
    localparam int HI_W    = INNER_W - LO_W;
    localparam int PLO_W   = LO_W + 1 + wdqi_pkg::TEMP_W;
    localparam int PHI_W   = HI_W + wdqi_pkg::TEMP_W;

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic ready2, ready3, ready4, ready5;

    wdqi_pkg::side_t side2_reg, side3_reg, side4_reg, side5_reg;
    logic [wdqi_pkg::DENS_W-1:0] d02_reg, d03_reg, d04_reg, d05_reg;
    logic signed [wdqi_pkg::TEMP_W-1:0] x2_reg, x3_reg;
    logic signed [wdqi_pkg::DL1_W-1:0]  dl12_reg;

    logic signed [M1_W-1:0]    m1_reg, m1_next;
    logic signed [INNER_W-1:0] inner_reg, inner_next;
    logic signed [LO_W:0]      inner_lo;
    logic signed [HI_W-1:0]    inner_hi;
    logic signed [PLO_W-1:0]   plo_reg, plo_next;
    logic signed [PHI_W-1:0]   phi_reg, phi_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;

    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign in_ready = ready2;

    always_comb begin
        m1_next    = in_dl2 * in_xm;
        inner_next = INNER_W'(m1_reg) + (INNER_W'(dl12_reg) <<< (FRAC_BITS + 1));
        // Split the wide factor so each product stays near 24 by 16 bits.
        inner_lo   = $signed({1'b0, inner_reg[LO_W-1:0]});
        inner_hi   = $signed(inner_reg[INNER_W-1:LO_W]);
        plo_next   = inner_lo * x3_reg;
        phi_next   = inner_hi * x3_reg;
        prod_next  = (PROD_W'(phi_reg) <<< LO_W) + PROD_W'(plo_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (ready2) begin
                v2_reg <= in_valid;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
            if (ready4) begin
                v4_reg <= v3_reg;
            end
            if (ready5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && in_valid) begin
            side2_reg <= in_side;
            d02_reg   <= in_d0;
            x2_reg    <= in_x;
            dl12_reg  <= in_dl1;
            m1_reg    <= m1_next;
        end
        if (ready3 && v2_reg) begin
            side3_reg <= side2_reg;
            d03_reg   <= d02_reg;
            x3_reg    <= x2_reg;
            inner_reg <= inner_next;
        end
        if (ready4 && v3_reg) begin
            side4_reg <= side3_reg;
            d04_reg   <= d03_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
        end
        if (ready5 && v4_reg) begin
            side5_reg <= side4_reg;
            d05_reg   <= d04_reg;
            prod_reg  <= prod_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_side  = side5_reg;
    assign out_d0    = d05_reg;
    assign out_prod  = prod_reg;

endmodule

`default_nettype wire

>>> rtl/core/wdqi_round.sv
`default_nettype none

module wdqi_round #(
    parameter int FRAC_BITS = wdqi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire wdqi_pkg::side_t                               in_side,
    input  wire logic [wdqi_pkg::DENS_W-1:0]                   in_d0,
    input  wire logic signed [wdqi_pkg::prod_width(FRAC_BITS)-1:0] in_prod,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic [wdqi_pkg::DENS_W-1:0]                        out_value,
    output wdqi_pkg::range_flag_t                              out_flag
);

    localparam int PROD_W = wdqi_pkg::prod_width(FRAC_BITS);
    localparam int N_W    = PROD_W + 1;
    localparam int RND_SH = 2 * FRAC_BITS + 1;
    localparam int DENS_W = wdqi_pkg::DENS_W;
    localparam logic signed [N_W-1:0] HALF = {{(N_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

    logic v6_reg, v7_reg;
    logic ready6, ready7;

    wdqi_pkg::side_t        side6_reg;
    logic [N_W-1:0]         base;
    logic signed [N_W-1:0]  n_reg, n_next;
    logic [DENS_W-1:0]      value_reg, value_next;
    wdqi_pkg::range_flag_t  flag_reg;

    assign ready7   = !v7_reg || out_ready;
    assign ready6   = !v6_reg || ready7;
    assign in_ready = ready6;

    always_comb begin
        base   = N_W'(in_d0) << RND_SH;
        n_next = N_W'(in_prod) + $signed(base) + HALF;

        // Out-of-range items take their default density; others round half up, then clamp to the 24-bit output range.
        if (side6_reg.flag != wdqi_pkg::FLAG_INTERP) begin
            value_next = side6_reg.dflt;
        end else if (n_reg[N_W-1]) begin
            value_next = '0;
        end else if (|n_reg[N_W-2:RND_SH+DENS_W]) begin
            value_next = '1;
        end else begin
            value_next = n_reg[RND_SH+DENS_W-1:RND_SH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (ready6) begin
                v6_reg <= in_valid;
            end
            if (ready7) begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready6 && in_valid) begin
            side6_reg <= in_side;
            n_reg     <= n_next;
        end
        if (ready7 && v6_reg) begin
            value_reg <= value_next;
            flag_reg  <= side6_reg.flag;
        end
    end

    assign out_valid = v7_reg;
    assign out_value = value_reg;
    assign out_flag  = flag_reg;

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int FRAC    = wdqi_pkg::FRAC_BITS_DEF;
    localparam int TOP_IDX = wdqi_pkg::TABLE_DEPTH_DEF - 3;

    typedef struct {
        logic [wdqi_pkg::DENS_W-1:0] density;
        wdqi_pkg::range_flag_t       flag;
    } density_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    wire logic                       s_tready;
    logic [15:0]                     s_tdata   = '0;
    wire logic                       m_tvalid;
    logic                            m_tready  = 1'b0;
    wire logic [23:0]                m_tdata;
    wire logic [1:0]                 m_tuser;
    logic                            cfg_valid = 1'b0;
    wire logic                       cfg_ready;
    logic [wdqi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wdqi_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Register copies used by the density predictor.
    logic signed [wdqi_pkg::TEMP_W-1:0] lim_low    = wdqi_pkg::LOW_LIMIT_RST;
    logic signed [wdqi_pkg::TEMP_W-1:0] lim_high   = wdqi_pkg::HIGH_LIMIT_RST;
    logic [wdqi_pkg::DENS_W-1:0]        dens_below = wdqi_pkg::DENS_BELOW_RST;
    logic [wdqi_pkg::DENS_W-1:0]        dens_above = wdqi_pkg::DENS_ABOVE_RST;

    logic [15:0]     temp_queue[$];
    density_result_t pending_density[$];

    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    int send_gap     = 0;
    int recv_stall   = 0;
    int error_count  = 0;

    water_density_quadratic_interp_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic density_result_t interp_density(input logic signed [15:0] temp);
        density_result_t res;
        longint t0, x, n, r, d0, d1, d2, s;
        s = longint'(1) << FRAC;
        res.flag = wdqi_pkg::FLAG_INTERP;
        res.density = '0;
        if (temp <= lim_low) begin
            res.flag = wdqi_pkg::FLAG_BELOW;
            res.density = dens_below;
        end else if (temp >= lim_high) begin
            res.flag = wdqi_pkg::FLAG_ABOVE;
            res.density = dens_above;
        end else begin
            // Negative temperatures extrapolate from the first entry, hot ones from the top.
            t0 = (temp < 0) ? 0 : (longint'(temp) >>> FRAC);
            if (t0 > TOP_IDX) begin
                t0 = TOP_IDX;
            end
            d0 = longint'(wdqi_pkg::DENS_ROM[int'(t0)]);
            d1 = longint'(wdqi_pkg::DENS_ROM[int'(t0) + 1]);
            d2 = longint'(wdqi_pkg::DENS_ROM[int'(t0) + 2]);
            x = longint'(temp) - t0 * s;
            n = d0 * ((x - s) * (x - 2 * s))
              - 2 * d1 * (x * (x - 2 * s))
              + d2 * (x * (x - s));
            n = n + (longint'(1) << (2 * FRAC));
            if (n >= 0) begin
                r = n >>> (2 * FRAC + 1);
                res.density = (r > longint'(24'hFFFFFF)) ? 24'hFFFFFF :
                              r[wdqi_pkg::DENS_W-1:0];
            end
        end
        return res;
    endfunction

    // Mostly temperatures inside the current limits, plus boundary hits and full-range noise.
    function automatic logic [15:0] pick_temp();
        int lo, hi, sel, v;
        lo = lim_low;
        hi = lim_high;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            v = $urandom_range(0, 65535) - 32768;
        end else if (sel < 27) begin
            v = lo + $urandom_range(0, 6) - 3;
        end else if (sel < 39) begin
            v = hi + $urandom_range(0, 6) - 3;
        end else if (hi - lo >= 2) begin
            v = lo + 1 + $urandom_range(0, hi - lo - 2);
        end else begin
            v = $urandom_range(0, 65535) - 32768;
        end
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    task automatic queue_random(input int count);
        repeat (count) temp_queue.push_back(pick_temp());
    endtask

    task automatic write_reg(input wdqi_pkg::cfg_reg_t idx,
                             input logic [wdqi_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            wdqi_pkg::REG_LOW_LIMIT:  lim_low    = val[wdqi_pkg::TEMP_W-1:0];
            wdqi_pkg::REG_HIGH_LIMIT: lim_high   = val[wdqi_pkg::TEMP_W-1:0];
            wdqi_pkg::REG_DENS_BELOW: dens_below = val[wdqi_pkg::DENS_W-1:0];
            wdqi_pkg::REG_DENS_ABOVE: dens_above = val[wdqi_pkg::DENS_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (temp_queue.size() != 0 || s_tvalid || pending_density.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    // Temperature driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_density.push_back(interp_density(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (temp_queue.size() != 0) begin
                    s_tdata  <= temp_queue.pop_front();
                    s_tvalid <= 1'b1;
                    if (send_idle_on && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 17);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Density monitor.
    always @(posedge aclk) begin
        density_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_density.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= 10) begin
                        $display("ERROR: unexpected item density=%0d flag=%0d", m_tdata, m_tuser);
                    end
                end else begin
                    want = pending_density.pop_front();
                    if (m_tdata !== want.density || m_tuser !== want.flag) begin
                        error_count = error_count + 1;
                        if (error_count <= 10) begin
                            $display("ERROR: density expected %0d got %0d, flag expected %0d got %0d",
                                     want.density, m_tdata, want.flag, m_tuser);
                        end
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall = recv_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_idle_on && $urandom_range(0, 7) == 0) begin
                    recv_stall = $urandom_range(1, 17);
                end
            end
        end
    end

    initial begin
        int lo, hi;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limits: edges of the table, exact boundaries, top-entry clamp, field extremes.
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        temp_queue = '{16'd0, 16'd1, 16'd128, 16'd255, 16'd256, 16'd257, 16'd12345,
                       16'd25343, 16'd25344, 16'd25599, 16'd25600, 16'h7FFF, 16'h8000,
                       16'hFFFF};
        queue_random(200);
        wait_idle();

        // Widest limits: negative and past-the-top temperatures are extrapolated.
        write_reg(wdqi_pkg::REG_LOW_LIMIT, 24'h008000);
        write_reg(wdqi_pkg::REG_HIGH_LIMIT, 24'h007FFF);
        write_reg(wdqi_pkg::REG_DENS_BELOW, 24'h000000);
        write_reg(wdqi_pkg::REG_DENS_ABOVE, 24'hFFFFFF);
        recv_idle_on = 1'b0;
        temp_queue = '{16'h8000, 16'h7FFF, 16'h8001, 16'hFF00, 16'hFFFF, 16'h7FFE,
                       16'd30000, 16'd25600, 16'd26000};
        queue_random(200);
        wait_idle();

        // Overlapping limits: the below case takes precedence.
        write_reg(wdqi_pkg::REG_LOW_LIMIT, 24'd12800);
        write_reg(wdqi_pkg::REG_HIGH_LIMIT, 24'd2560);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b1;
        temp_queue = '{16'd2560, 16'd12800, 16'd12801, 16'd20000, 16'hFF9C};
        queue_random(100);
        wait_idle();

        send_idle_on = 1'b1;
        repeat (3) begin
            lo = $urandom_range(0, 25600) - 12800;
            hi = lo + $urandom_range(256, 20000);
            if (hi > 32767) begin
                hi = 32767;
            end
            write_reg(wdqi_pkg::REG_LOW_LIMIT, {8'h00, lo[15:0]});
            write_reg(wdqi_pkg::REG_HIGH_LIMIT, {8'h00, hi[15:0]});
            write_reg(wdqi_pkg::REG_DENS_BELOW, 24'($urandom_range(0, 24'hFFFFFF)));
            write_reg(wdqi_pkg::REG_DENS_ABOVE, 24'($urandom_range(0, 24'hFFFFFF)));
            queue_random(150);
            wait_idle();
        end

        // Back to the power-up settings at full rate.
        write_reg(wdqi_pkg::REG_LOW_LIMIT, {8'h00, wdqi_pkg::LOW_LIMIT_RST});
        write_reg(wdqi_pkg::REG_HIGH_LIMIT, {8'h00, wdqi_pkg::HIGH_LIMIT_RST});
        write_reg(wdqi_pkg::REG_DENS_BELOW, wdqi_pkg::DENS_BELOW_RST);
        write_reg(wdqi_pkg::REG_DENS_ABOVE, wdqi_pkg::DENS_ABOVE_RST);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        queue_random(200);
        wait_idle();

        if (pending_density.size() != 0) begin
            error_count = error_count + pending_density.size();
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
